FILE: design/tcsg_pkg.sv
`timescale 1ns / 1ps

package tcsg_pkg;

	// Event kinds carried in the input tuser field.
	localparam logic [1:0] KIND_FRAME = 2'd0;
	localparam logic [1:0] KIND_TICK  = 2'd1;
	localparam logic [1:0] KIND_BUS   = 2'd2;

	// Fault codes.
	localparam logic [2:0] FLT_OK      = 3'd0;
	localparam logic [2:0] FLT_CRC     = 3'd1;
	localparam logic [2:0] FLT_SEND    = 3'd2;
	localparam logic [2:0] FLT_BUS     = 3'd3;
	localparam logic [2:0] FLT_STARTUP = 3'd4;
	localparam logic [2:0] FLT_TIMEOUT = 3'd5;
	localparam logic [2:0] FLT_INVALID = 3'd6;

	// Configuration register indexes.
	localparam logic [2:0] CFG_COMMAND_ADDRESS = 3'd0;
	localparam logic [2:0] CFG_TORQUE_LIMIT    = 3'd1;
	localparam logic [2:0] CFG_RATE_DELTA      = 3'd2;
	localparam logic [2:0] CFG_RATE_INTERVAL   = 3'd3;
	localparam logic [2:0] CFG_TIMEOUT_LIMIT   = 3'd4;

	// Configuration reset values.
	localparam logic [10:0] RST_COMMAND_ADDRESS = 11'h250;
	localparam logic [14:0] RST_TORQUE_LIMIT    = 15'd1500;
	localparam logic [14:0] RST_RATE_DELTA      = 15'd375;
	localparam logic [31:0] RST_RATE_INTERVAL   = 32'd250000;
	localparam logic [7:0]  RST_TIMEOUT_LIMIT   = 8'd10;

	localparam logic [7:0] CRC_INIT = 8'hFF;
	localparam logic [7:0] CRC_POLY = 8'hD5;

	localparam int COUNTER_BITS_DEF = 4;
	localparam int QUEUE_DEPTH_DEF  = 2;

	typedef struct packed {
		logic [10:0] command_address;
		logic [14:0] torque_limit;
		logic [14:0] rate_delta;
		logic [31:0] rate_interval;
		logic [7:0]  timeout_limit;
	} cfg_t;

	// One classified event as it waits between the front and the back end.
	typedef struct packed {
		logic [1:0]         kind;
		logic               id_match;
		logic               crc_ok;
		logic signed [15:0] cmd_a;
		logic signed [15:0] cmd_b;
		logic [7:0]         byte4;
		logic [31:0]        arrival_time;
		logic               mailbox_free;
		logic [11:0]        sensor_a;
		logic [11:0]        sensor_b;
	} entry_t;

	typedef struct packed {
		logic [2:0]         fault_code;
		logic signed [15:0] command_a;
		logic signed [15:0] command_b;
		logic               status_valid;
		logic [47:0]        status_payload;
	} result_t;

	// CRC-8, MSB first, over five bytes; the first byte fed sits in bits 39:32.
	function automatic logic [7:0] crc8_5(input logic [39:0] bytes);
		logic [7:0] c;
		c = CRC_INIT;
		for (int j = 0; j < 5; j++) begin
			c = c ^ bytes[39 - 8 * j -: 8];
			for (int k = 0; k < 8; k++) begin
				c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

FILE: design/tcsg_front.sv
`timescale 1ns / 1ps

// Unpacks an input event, matches the identifier and checks the frame CRC.
module tcsg_front (
	input  logic [1:0]       kind,
	input  logic [10:0]      frame_id,
	input  logic [47:0]      frame_payload,
	input  logic [31:0]      arrival_time,
	input  logic             mailbox_free,
	input  logic [11:0]      sensor_a,
	input  logic [11:0]      sensor_b,
	input  tcsg_pkg::cfg_t   cfg,
	output tcsg_pkg::entry_t entry
);

	logic [7:0] crc_calc;

	// Bytes are fed in the order 4, 3, 2, 1, 0; byte 0 is the top of the payload.
	assign crc_calc = tcsg_pkg::crc8_5({frame_payload[15:8], frame_payload[23:16],
		frame_payload[31:24], frame_payload[39:32], frame_payload[47:40]});

	always_comb begin
		entry.kind         = kind;
		entry.id_match     = (frame_id == cfg.command_address);
		entry.crc_ok       = (crc_calc == frame_payload[7:0]);
		entry.cmd_a        = $signed(frame_payload[47:32]);
		entry.cmd_b        = $signed(frame_payload[31:16]);
		entry.byte4        = frame_payload[15:8];
		entry.arrival_time = arrival_time;
		entry.mailbox_free = mailbox_free;
		entry.sensor_a     = sensor_a;
		entry.sensor_b     = sensor_b;
	end

endmodule

FILE: design/tcsg_queue.sv
`timescale 1ns / 1ps

// Small first-in first-out queue of classified events.
module tcsg_queue #(
	parameter int DEPTH = tcsg_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tcsg_pkg::entry_t push_entry,
	output logic             not_full,
	input  logic             pop,
	output logic             not_empty,
	output tcsg_pkg::entry_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	tcsg_pkg::entry_t mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign not_full  = (count_q != CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];
	assign do_push   = push && not_full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: design/tcsg_back.sv
`timescale 1ns / 1ps

// Applies one event per cycle to the safety state unless the result stalls; registers the result.
module tcsg_back #(
	parameter int COUNTER_BITS = tcsg_pkg::COUNTER_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tcsg_pkg::cfg_t    cfg,
	input  logic              entry_valid,
	input  tcsg_pkg::entry_t  entry,
	output logic              pop,
	output logic              res_valid,
	input  logic              res_ready,
	output tcsg_pkg::result_t res
);

	localparam int CB = COUNTER_BITS;

	logic [2:0]         fault_q, fault_d;
	logic [CB-1:0]      last_ctr_q, last_ctr_d;
	logic [CB-1:0]      stat_ctr_q, stat_ctr_d;
	logic [7:0]         silence_q, silence_d;
	logic signed [15:0] held_a_q, held_a_d;
	logic signed [15:0] held_b_q, held_b_d;
	logic signed [15:0] ref_a_q, ref_a_d;
	logic signed [15:0] ref_b_q, ref_b_d;
	logic [31:0]        ref_time_q, ref_time_d;
	logic               res_valid_q;
	tcsg_pkg::result_t  res_q, res_d;

	logic               en;
	logic [CB-1:0]      idx;
	logic               bad;
	logic               renew;
	logic signed [16:0] lim_pos;
	logic signed [16:0] lim_neg;
	logic signed [16:0] va_x;
	logic signed [16:0] vb_x;
	logic [7:0]         st_b4;
	logic [7:0]         st_crc;

	function automatic logic rate_bad(input logic signed [15:0] v,
			input logic signed [15:0] refv, input logic [14:0] d);
		logic signed [17:0] v_x;
		logic signed [17:0] r_x;
		logic signed [17:0] d_x;
		logic signed [17:0] hi;
		logic signed [17:0] lo;
		v_x = {{2{v[15]}}, v};
		r_x = {{2{refv[15]}}, refv};
		d_x = $signed({3'b000, d});
		hi  = ((r_x > 0) ? r_x : 18'sd0) + d_x;
		lo  = ((r_x < 0) ? r_x : 18'sd0) - d_x;
		return (v_x > hi) || (v_x < lo);
	endfunction

	assign pop       = entry_valid && (!res_valid_q || res_ready);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign en      = entry.byte4[7];
	assign idx     = entry.byte4[CB-1:0];
	assign lim_pos = $signed({2'b00, cfg.torque_limit});
	assign lim_neg = -lim_pos;
	assign va_x    = {entry.cmd_a[15], entry.cmd_a};
	assign vb_x    = {entry.cmd_b[15], entry.cmd_b};
	assign bad     = (va_x > lim_pos) || (va_x < lim_neg) || (vb_x > lim_pos)
		|| (vb_x < lim_neg) || rate_bad(entry.cmd_a, ref_a_q, cfg.rate_delta)
		|| rate_bad(entry.cmd_b, ref_b_q, cfg.rate_delta);
	assign renew   = ((entry.arrival_time - ref_time_q) > cfg.rate_interval);

	// The status frame carries the fault as it stood before the tick.
	assign st_b4  = 8'({fault_q, 4'b0000}) | 8'(stat_ctr_q);
	assign st_crc = tcsg_pkg::crc8_5({st_b4, entry.sensor_b[7:0], 4'b0000,
		entry.sensor_b[11:8], entry.sensor_a[7:0], 4'b0000, entry.sensor_a[11:8]});

	always_comb begin
		fault_d    = fault_q;
		last_ctr_d = last_ctr_q;
		stat_ctr_d = stat_ctr_q;
		silence_d  = silence_q;
		held_a_d   = held_a_q;
		held_b_d   = held_b_q;
		ref_a_d    = ref_a_q;
		ref_b_d    = ref_b_q;
		ref_time_d = ref_time_q;
		res_d.status_valid   = 1'b0;
		res_d.status_payload = '0;
		case (entry.kind)
			tcsg_pkg::KIND_FRAME: begin
				if (entry.id_match) begin
					if (!entry.crc_ok) begin
						fault_d = tcsg_pkg::FLT_CRC;
					end else begin
						if ((last_ctr_q + 1'b1) == idx) begin
							if (en) begin
								if (renew) begin
									ref_a_d    = entry.cmd_a;
									ref_b_d    = entry.cmd_b;
									ref_time_d = entry.arrival_time;
								end
								if (bad) begin
									ref_a_d    = '0;
									ref_b_d    = '0;
									ref_time_d = entry.arrival_time;
									fault_d    = tcsg_pkg::FLT_INVALID;
								end else begin
									held_a_d = entry.cmd_a;
									held_b_d = entry.cmd_b;
								end
							end else begin
								fault_d  = (entry.cmd_a == 0 && entry.cmd_b == 0) ?
									tcsg_pkg::FLT_OK : tcsg_pkg::FLT_INVALID;
								held_a_d = '0;
								held_b_d = '0;
							end
							silence_d = '0;
						end
						last_ctr_d = idx;
					end
				end
			end
			tcsg_pkg::KIND_TICK: begin
				if (entry.mailbox_free) begin
					res_d.status_valid   = 1'b1;
					res_d.status_payload = {4'b0000, entry.sensor_a, 4'b0000,
						entry.sensor_b, st_b4, st_crc};
					stat_ctr_d = stat_ctr_q + 1'b1;
				end else begin
					fault_d = tcsg_pkg::FLT_SEND;
				end
				if (silence_q == cfg.timeout_limit) begin
					fault_d = tcsg_pkg::FLT_TIMEOUT;
				end else begin
					silence_d = silence_q + 8'd1;
				end
			end
			tcsg_pkg::KIND_BUS: begin
				fault_d = tcsg_pkg::FLT_BUS;
			end
			default: begin
			end
		endcase
		res_d.fault_code = fault_d;
		res_d.command_a  = held_a_d;
		res_d.command_b  = held_b_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_q     <= tcsg_pkg::FLT_STARTUP;
			last_ctr_q  <= '0;
			stat_ctr_q  <= '0;
			silence_q   <= '0;
			held_a_q    <= '0;
			held_b_q    <= '0;
			ref_a_q     <= '0;
			ref_b_q     <= '0;
			ref_time_q  <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				fault_q    <= fault_d;
				last_ctr_q <= last_ctr_d;
				stat_ctr_q <= stat_ctr_d;
				silence_q  <= silence_d;
				held_a_q   <= held_a_d;
				held_b_q   <= held_b_d;
				ref_a_q    <= ref_a_d;
				ref_b_q    <= ref_b_d;
				ref_time_q <= ref_time_d;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_d;
		end
	end

	a_no_pop_while_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!(res_valid_q && !res_ready && pop))
		else $error("event consumed while the result register is stalled");

	a_bus_sets_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && entry.kind == tcsg_pkg::KIND_BUS) |=>
		(res_valid_q && res_q.fault_code == tcsg_pkg::FLT_BUS))
		else $error("bus error event did not report a bus fault");

	a_status_only_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && entry.kind != tcsg_pkg::KIND_TICK) |=> !res_q.status_valid)
		else $error("status frame reported for an event that is not a tick");

	a_status_counter_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !(entry.kind == tcsg_pkg::KIND_TICK && entry.mailbox_free))
		|=> $stable(stat_ctr_q))
		else $error("status counter moved without a sent status frame");

endmodule

FILE: design/torque_command_safety_gate.sv
`timescale 1ns / 1ps

// Torque command safety gate.
// Input stream: one event per transaction. s_tuser holds the event kind (frame,
// transmit tick or bus error); s_tdata holds the frame identifier and payload,
// the arrival timestamp, the mailbox-free flag and both sensor samples.
// Output stream: exactly one result per event, in order. m_tdata holds the fault
// code, the held torque commands and the status frame; m_tuser flags a status
// frame that was sent at a tick.
// The front end classifies an event (identifier match, frame CRC) as it is
// accepted and writes it to a short queue; the back end takes one event a cycle
// from the queue while the result register is not stalled, updates the safety
// state and loads the result register. An event passes through the queue and
// then the result register before m_tvalid rises for it. Throughput is one
// event per cycle while the receiver does not stall. When the receiver stalls,
// the result register holds, the queue fills and s_tready drops once it is
// full. The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
// is always ready; the user must write it only while idle, as the block does
// not enforce this. Reset clears the queue and the result valid flag, loads the
// configuration defaults and sets the startup fault with all commands at zero.
module torque_command_safety_gate #(
	parameter int COUNTER_BITS = tcsg_pkg::COUNTER_BITS_DEF,
	parameter int QUEUE_DEPTH  = tcsg_pkg::QUEUE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// s_tdata from bit 0: frame_id, frame_payload, arrival_time, mailbox_free,
	// sensor_a, sensor_b, zero fill.
	input  logic [119:0] s_tdata,
	// s_tuser: kind.
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// m_tdata from bit 0: fault_code, command_a, command_b, status_payload,
	// zero fill.
	output logic [87:0]  m_tdata,
	// m_tuser: status_valid.
	output logic [0:0]   m_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	tcsg_pkg::cfg_t    cfg_q;
	tcsg_pkg::entry_t  front_entry;
	tcsg_pkg::entry_t  head;
	tcsg_pkg::result_t res;
	logic              queue_not_full;
	logic              queue_not_empty;
	logic              pop;

	assign cfg_ready = 1'b1;

	// Configuration registers; writes to an index beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.command_address <= tcsg_pkg::RST_COMMAND_ADDRESS;
			cfg_q.torque_limit    <= tcsg_pkg::RST_TORQUE_LIMIT;
			cfg_q.rate_delta      <= tcsg_pkg::RST_RATE_DELTA;
			cfg_q.rate_interval   <= tcsg_pkg::RST_RATE_INTERVAL;
			cfg_q.timeout_limit   <= tcsg_pkg::RST_TIMEOUT_LIMIT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tcsg_pkg::CFG_COMMAND_ADDRESS: cfg_q.command_address <= cfg_data[10:0];
				tcsg_pkg::CFG_TORQUE_LIMIT:    cfg_q.torque_limit    <= cfg_data[14:0];
				tcsg_pkg::CFG_RATE_DELTA:      cfg_q.rate_delta      <= cfg_data[14:0];
				tcsg_pkg::CFG_RATE_INTERVAL:   cfg_q.rate_interval   <= cfg_data;
				tcsg_pkg::CFG_TIMEOUT_LIMIT:   cfg_q.timeout_limit   <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	tcsg_front u_front (
		.kind          (s_tuser),
		.frame_id      (s_tdata[10:0]),
		.frame_payload (s_tdata[58:11]),
		.arrival_time  (s_tdata[90:59]),
		.mailbox_free  (s_tdata[91]),
		.sensor_a      (s_tdata[103:92]),
		.sensor_b      (s_tdata[115:104]),
		.cfg           (cfg_q),
		.entry         (front_entry)
	);

	tcsg_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (s_tvalid),
		.push_entry (front_entry),
		.not_full   (queue_not_full),
		.pop        (pop),
		.not_empty  (queue_not_empty),
		.head       (head)
	);

	assign s_tready = queue_not_full;

	tcsg_back #(
		.COUNTER_BITS (COUNTER_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.entry_valid (queue_not_empty),
		.entry       (head),
		.pop         (pop),
		.res_valid   (m_tvalid),
		.res_ready   (m_tready),
		.res         (res)
	);

	assign m_tdata = {5'b00000, res.status_payload, res.command_b, res.command_a,
		res.fault_code};
	assign m_tuser = res.status_valid;

endmodule

FILE: tb/sv/torque_command_safety_gate_test.sv
`timescale 1ns / 1ps

module torque_command_safety_gate_test;

	// One event as it travels on the input stream.
	typedef struct packed {
		logic [1:0]  kind;
		logic [10:0] frame_id;
		logic [47:0] payload;
		logic [31:0] arrival;
		logic        mailbox_free;
		logic [11:0] sensor_a;
		logic [11:0] sensor_b;
	} gate_event_t;

	localparam int CYCLE_LIMIT = 100000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [119:0] s_tdata = '0;
	logic [1:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [87:0]  m_tdata;
	logic [0:0]   m_tuser;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [2:0]   cfg_index = '0;
	logic [31:0]  cfg_data = '0;

	torque_command_safety_gate dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Configuration as the predictor sees it. It changes only while the gate is idle.
	logic [10:0] rx_address   = tcsg_pkg::RST_COMMAND_ADDRESS;
	logic [14:0] abs_limit    = tcsg_pkg::RST_TORQUE_LIMIT;
	logic [14:0] step_limit   = tcsg_pkg::RST_RATE_DELTA;
	logic [31:0] renew_period = tcsg_pkg::RST_RATE_INTERVAL;
	logic [7:0]  silence_max  = tcsg_pkg::RST_TIMEOUT_LIMIT;

	// Safety state of the predictor, starting from the reset values.
	logic [2:0]         fault_now   = tcsg_pkg::FLT_STARTUP;
	logic [3:0]         ctr_last    = '0;
	logic [7:0]         silence     = '0;
	logic signed [15:0] held_a      = '0;
	logic signed [15:0] held_b      = '0;
	logic signed [15:0] anchor_a    = '0;
	logic signed [15:0] anchor_b    = '0;
	logic [31:0]        anchor_time = '0;
	logic [3:0]         beacon_ctr  = '0;

	// Events waiting for the driver, and results waiting for the gate.
	gate_event_t         event_queue[$];
	tcsg_pkg::result_t   pending_results[$];
	gate_event_t         cur_ev;
	bit          took_in = 1'b0;
	bit          calm = 1'b0;
	int          n_queued = 0;
	int          n_taken = 0;
	int          n_results = 0;
	int          n_status = 0;
	int          n_invalid = 0;
	int          errors = 0;
	int          cycles = 0;

	// Generator view of the sequence: the counter that the gate last recorded
	// and the running arrival timer.
	logic [3:0]  gen_ctr = '0;
	logic [31:0] gen_time = 32'd1000;

	// CRC-8 over five bytes, the byte in the lowest bits fed first. A frame body
	// holds byte 4 in its lowest bits, which is exactly the order the gate uses.
	function automatic logic [7:0] frame_crc(input logic [39:0] body);
		logic [7:0] c;
		c = 8'hFF;
		for (int j = 0; j < 5; j++) begin
			c = c ^ body[8 * j +: 8];
			for (int k = 0; k < 8; k++) begin
				c = c[7] ? ({c[6:0], 1'b0} ^ 8'hD5) : {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

	// A command lies outside the rate window if it passes the anchor by more
	// than the allowed step; the window always contains zero.
	function automatic bit outside_window(input int v, input int anchor, input int step);
		int hi;
		int lo;
		hi = (anchor > 0 ? anchor : 0) + step;
		lo = (anchor < 0 ? anchor : 0) - step;
		return v > hi || v < lo;
	endfunction

	// Updates the predicted state with one event and returns the result that
	// the gate must report for it.
	function automatic tcsg_pkg::result_t gate_response(input gate_event_t ev);
		tcsg_pkg::result_t  r;
		logic signed [15:0] va;
		logic signed [15:0] vb;
		logic [7:0]         b4;
		logic [3:0]         next_ctr;
		logic [31:0]        since;
		logic [39:0]        body;
		int                 lim;
		bit                 bad;
		r = '0;
		case (ev.kind)
			tcsg_pkg::KIND_FRAME: begin
				if (ev.frame_id == rx_address) begin
					if (frame_crc(ev.payload[47:8]) != ev.payload[7:0]) begin
						fault_now = tcsg_pkg::FLT_CRC;
					end else begin
						va = ev.payload[47:32];
						vb = ev.payload[31:16];
						b4 = ev.payload[15:8];
						next_ctr = ctr_last + 4'd1;
						if (next_ctr == b4[3:0]) begin
							if (b4[7]) begin
								lim = int'(abs_limit);
								bad = va > lim || va < -lim || vb > lim || vb < -lim;
								bad |= outside_window(va, anchor_a, int'(step_limit));
								bad |= outside_window(vb, anchor_b, int'(step_limit));
								since = ev.arrival - anchor_time;
								if (since > renew_period) begin
									anchor_a = va;
									anchor_b = vb;
									anchor_time = ev.arrival;
								end
								if (bad) begin
									anchor_a = '0;
									anchor_b = '0;
									anchor_time = ev.arrival;
									fault_now = tcsg_pkg::FLT_INVALID;
								end else begin
									held_a = va;
									held_b = vb;
								end
							end else begin
								fault_now = (va == 0 && vb == 0) ?
									tcsg_pkg::FLT_OK : tcsg_pkg::FLT_INVALID;
								held_a = '0;
								held_b = '0;
							end
							silence = '0;
						end
						ctr_last = b4[3:0];
					end
				end
			end
			tcsg_pkg::KIND_TICK: begin
				if (ev.mailbox_free) begin
					// The status frame reports the fault as it stood before this tick.
					body = {4'd0, ev.sensor_a, 4'd0, ev.sensor_b, 1'b0, fault_now, beacon_ctr};
					r.status_payload = {body, frame_crc(body)};
					r.status_valid = 1'b1;
					beacon_ctr = beacon_ctr + 4'd1;
				end else begin
					fault_now = tcsg_pkg::FLT_SEND;
				end
				if (silence == silence_max) begin
					fault_now = tcsg_pkg::FLT_TIMEOUT;
				end else begin
					silence = silence + 8'd1;
				end
			end
			tcsg_pkg::KIND_BUS: begin
				fault_now = tcsg_pkg::FLT_BUS;
			end
			default: begin
			end
		endcase
		r.fault_code = fault_now;
		r.command_a = held_a;
		r.command_b = held_b;
		return r;
	endfunction

	// Picks a torque value: mostly inside both the absolute limit and the rate
	// window, some near the absolute limit, some anywhere, some at the extremes.
	function automatic logic signed [15:0] pick_torque();
		int span;
		int v;
		int r;
		r = $urandom_range(99);
		span = (abs_limit < step_limit) ? int'(abs_limit) : int'(step_limit);
		if (r < 65) begin
			v = int'($urandom_range(2 * span)) - span;
		end else if (r < 85) begin
			span = int'(abs_limit) + 40;
			v = int'($urandom_range(2 * span)) - span;
			if (v > 32767) v = 32767;
			if (v < -32768) v = -32768;
		end else if (r < 93) begin
			v = int'($urandom_range(65535)) - 32768;
		end else begin
			case ($urandom_range(4))
				0: v = 32767;
				1: v = -32768;
				2: v = 0;
				3: v = int'(abs_limit);
				default: v = -int'(abs_limit);
			endcase
		end
		return 16'(v);
	endfunction

	task automatic push_event(input gate_event_t ev);
		event_queue.push_back(ev);
		n_queued++;
	endtask

	// Queues a frame to the command address. A frame with a good checksum moves
	// the gate's counter, whether or not it was the one expected.
	task automatic push_command(input logic signed [15:0] a, input logic signed [15:0] b,
			input logic en, input logic [3:0] ctr, input bit corrupt);
		gate_event_t ev;
		logic [39:0] body;
		body = {a, b, en, 3'($urandom), ctr};
		ev.kind = tcsg_pkg::KIND_FRAME;
		ev.frame_id = rx_address;
		ev.payload = {body, frame_crc(body) ^ (corrupt ? 8'($urandom_range(1, 255)) : 8'd0)};
		ev.arrival = gen_time;
		ev.mailbox_free = 1'($urandom);
		ev.sensor_a = 12'($urandom);
		ev.sensor_b = 12'($urandom);
		if (!corrupt) gen_ctr = ctr;
		push_event(ev);
	endtask

	task automatic push_tick(input logic free, input logic [11:0] sa, input logic [11:0] sb);
		gate_event_t ev;
		ev = {tcsg_pkg::KIND_TICK, 11'($urandom), 48'({$urandom, $urandom}), $urandom, free,
			sa, sb};
		push_event(ev);
	endtask

	task automatic push_other(input logic [1:0] kind);
		gate_event_t ev;
		ev = {kind, 11'($urandom), 48'({$urandom, $urandom}), gen_time, 1'($urandom),
			12'($urandom), 12'($urandom)};
		// A frame on any other identifier must be ignored.
		if (kind == tcsg_pkg::KIND_FRAME && ev.frame_id == rx_address) begin
			ev.frame_id[0] = ~ev.frame_id[0];
		end
		push_event(ev);
	endtask

	// Random traffic: mostly well-formed command frames in sequence, mixed with
	// ticks, bus errors, out-of-sequence and corrupted frames and foreign frames.
	// Foreign frames are ignored by the gate and are not counted.
	task automatic random_events(input int count);
		int                 counted;
		int                 r;
		logic signed [15:0] a;
		logic signed [15:0] b;
		counted = 0;
		while (counted < count) begin
			r = $urandom_range(99);
			if (r < 15) gen_time = gen_time + renew_period + 32'($urandom_range(1, 50));
			else if (r < 25) gen_time = $urandom;
			else gen_time = gen_time + 32'($urandom_range(1, 3000));
			r = $urandom_range(99);
			counted++;
			if (r < 55) begin
				if ($urandom_range(99) < 80) begin
					push_command(pick_torque(), pick_torque(), 1'b1, gen_ctr + 4'd1, 1'b0);
				end else begin
					a = ($urandom_range(4) == 0) ? pick_torque() : 16'sd0;
					b = ($urandom_range(4) == 0) ? pick_torque() : 16'sd0;
					push_command(a, b, 1'b0, gen_ctr + 4'd1, 1'b0);
				end
			end else if (r < 62) begin
				push_command(pick_torque(), pick_torque(), 1'($urandom),
					gen_ctr + 4'($urandom_range(2, 15)), 1'b0);
			end else if (r < 66) begin
				push_command(pick_torque(), pick_torque(), 1'($urandom), gen_ctr + 4'd1, 1'b1);
			end else if (r < 70) begin
				push_other(tcsg_pkg::KIND_FRAME);
				counted--;
			end else if (r < 92) begin
				push_tick($urandom_range(99) < 85, 12'($urandom), 12'($urandom));
			end else begin
				push_other(tcsg_pkg::KIND_BUS);
			end
		end
	endtask

	// Waits until every queued event was taken and every result has come back,
	// then leaves a few quiet cycles before the next step.
	task automatic drain();
		do @(negedge clk); while (n_taken != n_queued || pending_results.size() != 0);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			tcsg_pkg::CFG_COMMAND_ADDRESS: rx_address = val[10:0];
			tcsg_pkg::CFG_TORQUE_LIMIT:    abs_limit = val[14:0];
			tcsg_pkg::CFG_RATE_DELTA:      step_limit = val[14:0];
			tcsg_pkg::CFG_RATE_INTERVAL:   renew_period = val;
			tcsg_pkg::CFG_TIMEOUT_LIMIT:   silence_max = val[7:0];
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_all(input logic [10:0] addr, input logic [14:0] lim,
			input logic [14:0] step, input logic [31:0] period, input logic [7:0] tout);
		write_reg(tcsg_pkg::CFG_COMMAND_ADDRESS, 32'(addr));
		write_reg(tcsg_pkg::CFG_TORQUE_LIMIT, 32'(lim));
		write_reg(tcsg_pkg::CFG_RATE_DELTA, 32'(step));
		write_reg(tcsg_pkg::CFG_RATE_INTERVAL, period);
		write_reg(tcsg_pkg::CFG_TIMEOUT_LIMIT, 32'(tout));
	endtask

	// Driver: presents the next queued event at the falling edge once the
	// previous transaction has completed, with random idle cycles unless the
	// run is in a calm stretch.
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || took_in) begin
			if (event_queue.size() != 0 && (calm || $urandom_range(99) >= 23)) begin
				cur_ev = event_queue.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= cur_ev.kind;
				s_tdata <= {4'd0, cur_ev.sensor_b, cur_ev.sensor_a, cur_ev.mailbox_free,
					cur_ev.arrival, cur_ev.payload, cur_ev.frame_id};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// The receiver stalls at random in the same way.
	always @(negedge clk) begin
		m_tready <= arst_n && (calm || $urandom_range(99) >= 23);
	end

	// Monitor: at each rising edge, predicts the result of an accepted input
	// transaction and checks an accepted output transaction against the oldest
	// prediction. The cycle counter ends a run that hangs.
	always @(posedge clk) begin : monitor
		tcsg_pkg::result_t want;
		cycles++;
		took_in = arst_n && s_tvalid && s_tready;
		if (took_in) begin
			pending_results.push_back(gate_response(cur_ev));
			n_taken++;
		end
		if (arst_n && m_tvalid && m_tready) begin
			n_results++;
			if (pending_results.size() == 0) begin
				$error("result transaction arrived with no event waiting for it");
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[2:0] !== want.fault_code) begin
					$error("fault_code: expected %0d, got %0d", want.fault_code, m_tdata[2:0]);
					errors++;
				end
				if (m_tdata[18:3] !== want.command_a) begin
					$error("command_a: expected %0d, got %0d", want.command_a,
						$signed(m_tdata[18:3]));
					errors++;
				end
				if (m_tdata[34:19] !== want.command_b) begin
					$error("command_b: expected %0d, got %0d", want.command_b,
						$signed(m_tdata[34:19]));
					errors++;
				end
				if (m_tuser[0] !== want.status_valid) begin
					$error("status_valid: expected %0d, got %0d", want.status_valid, m_tuser[0]);
					errors++;
				end
				if (m_tdata[82:35] !== want.status_payload) begin
					$error("status_payload: expected %h, got %h", want.status_payload,
						m_tdata[82:35]);
					errors++;
				end
				if (want.status_valid) n_status++;
				if (want.fault_code == tcsg_pkg::FLT_INVALID) n_invalid++;
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("torque_command_safety_gate_test failed");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part with the reset configuration. Eleven ticks with no
		// command run the silence counter up to the timeout; one of them finds
		// the mailbox busy and the first two carry the sensor extremes.
		for (int i = 0; i < 11; i++) begin
			push_tick(i != 3, (i == 0) ? 12'hFFF : (i == 1) ? 12'h000 : 12'($urandom),
				(i == 0) ? 12'h000 : (i == 1) ? 12'hFFF : 12'($urandom));
		end
		push_other(tcsg_pkg::KIND_BUS);
		push_other(tcsg_pkg::KIND_FRAME);
		push_command(16'sd0, 16'sd0, 1'b0, gen_ctr + 4'd1, 1'b1);
		// Zero commands with the enable clear take the gate out of its fault.
		push_command(16'sd0, 16'sd0, 1'b0, gen_ctr + 4'd1, 1'b0);
		// Exactly at the rate window, then one step past it.
		push_command(16'sd375, -16'sd375, 1'b1, gen_ctr + 4'd1, 1'b0);
		push_command(16'sd376, 16'sd0, 1'b1, gen_ctr + 4'd1, 1'b0);
		push_command(16'sd0, 16'sd0, 1'b0, gen_ctr + 4'd1, 1'b0);
		// Past the absolute limit, then a nonzero command with the enable clear.
		push_command(16'sd1501, 16'sd0, 1'b1, gen_ctr + 4'd1, 1'b0);
		push_command(16'sd5, 16'sd0, 1'b0, gen_ctr + 4'd1, 1'b0);
		push_command(16'sd0, 16'sd0, 1'b0, gen_ctr + 4'd1, 1'b0);
		// A skipped counter value is only recorded; the frame after it counts.
		push_command(16'sd100, 16'sd100, 1'b1, gen_ctr + 4'd3, 1'b0);
		push_command(16'sd0, 16'sd0, 1'b0, gen_ctr + 4'd1, 1'b0);
		// After the interval the anchor moves to the new commands, which widens
		// the window on one side.
		gen_time = gen_time + 32'd300000;
		push_command(16'sd300, -16'sd300, 1'b1, gen_ctr + 4'd1, 1'b0);
		gen_time = gen_time + 32'd100;
		push_command(16'sd675, -16'sd675, 1'b1, gen_ctr + 4'd1, 1'b0);
		push_command(-16'sd32768, 16'sd32767, 1'b1, gen_ctr + 4'd1, 1'b0);
		random_events(135);
		drain();

		// Wide address, widest torque limit, no rate step, immediate anchor
		// renewal and a timeout limit of one.
		write_all(11'h7FF, 15'h7FFF, 15'd0, 32'd0, 8'd1);
		random_events(135);
		drain();

		// The opposite extremes, run without any idle cycles on either side.
		calm = 1'b1;
		write_all(11'h000, 15'd0, 15'h7FFF, 32'hFFFF_FFFF, 8'd255);
		random_events(135);
		drain();
		calm = 1'b0;

		write_all(11'($urandom), 15'($urandom_range(200, 3000)), 15'($urandom_range(50, 800)),
			32'($urandom_range(1000, 100000)), 8'($urandom_range(3, 40)));
		random_events(135);
		drain();

		$display("Checked %0d results from %0d events over four register settings;", n_results,
			n_taken);
		$display("%0d status frames were sent and %0d results reported an invalid command.",
			n_status, n_invalid);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("torque_command_safety_gate_test passed");
		end else begin
			$display("torque_command_safety_gate_test failed");
		end
		$finish;
	end

endmodule

FILE: filelist.f
design/tcsg_pkg.sv
design/tcsg_front.sv
design/tcsg_queue.sv
design/tcsg_back.sv
design/torque_command_safety_gate.sv
tb/sv/torque_command_safety_gate_test.sv
